### rtl/alias_address_table_defines.svh
// Assertion helpers for the block that checks itself.
`ifndef ALIAS_ADDRESS_TABLE_DEFINES_SVH
`define ALIAS_ADDRESS_TABLE_DEFINES_SVH

// Same-cycle implication.
`define AAT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("alias_address_table: same-cycle check failed");

// Next-cycle implication.
`define AAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("alias_address_table: next-cycle check failed");

`endif

### rtl/aat_pkg.sv
package aat_pkg;

   localparam int TABLE_DEPTH_DEF = 64;

   typedef enum logic [2:0] {
      CMD_ADD    = 3'd0,
      CMD_LOOKUP = 3'd1,
      CMD_UPDATE = 3'd2,
      CMD_DELETE = 3'd3,
      CMD_LIST   = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      STS_OK            = 3'd0,
      STS_ALIAS_MISSING = 3'd1,
      STS_ALIAS_EXISTS  = 3'd2,
      STS_ADDR_EXISTS   = 3'd3,
      STS_FULL          = 3'd4,
      STS_LOC_EMPTY     = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SHIFT,
      S_INSERT
   } state_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [15:0] name_hi;
      logic [63:0] name_lo;
   } entry_type;

   typedef struct packed {
      logic alias_eq;
      logic addr_eq;
      logic loc_eq;
   } match_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] addr;
      logic [15:0] alias_hi;
      logic [63:0] alias_lo;
      logic        last;
   } rsp_type;

   function automatic rsp_type make_rsp(status_type st, entry_type e, logic fin);
      rsp_type r;
      r.status   = st;
      r.addr     = e.ip;
      r.alias_hi = e.name_hi;
      r.alias_lo = e.name_lo;
      r.last     = fin;
      return r;
   endfunction

endpackage

### rtl/aat_store.sv
module aat_store import aat_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
   input  logic              clock,
   input  mem_ctl_type       ctl,
   input  logic [IDX_W-1:0]  rd_addr,
   input  logic [IDX_W-1:0]  wr_addr,
   input  entry_type         wr_data,
   output entry_type         rd_data
);

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/aat_match.sv
module aat_match import aat_pkg::*; (
   input  entry_type ent,
   input  entry_type key,
   output match_type mt
);

   always_comb begin
      mt.alias_eq = (ent.name_hi == key.name_hi) && (ent.name_lo == key.name_lo);
      mt.addr_eq  = (ent.ip == key.ip);
      // location: top two octets
      mt.loc_eq   = (ent.ip[31:16] == key.ip[31:16]);
   end

endmodule

### rtl/aat_seq.sv
module aat_seq import aat_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   localparam int IDX_W = $clog2(TABLE_DEPTH),
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_cmd,
   input  entry_type         req_key,
   output mem_ctl_type       mem_ctl,
   output logic [IDX_W-1:0]  rd_addr,
   output logic [IDX_W-1:0]  wr_addr,
   output entry_type         wr_data,
   input  entry_type         rd_data,
   output entry_type         cmp_key,
   input  match_type         mt,
   input  logic              out_free,
   output logic              out_load,
   output rsp_type           out_data,
   output logic [CNT_W-1:0]  count
);

   state_type        state_ff, state_in;
   logic [2:0]       cmd_ff, cmd_in;
   entry_type        key_ff, key_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic             hit_ff, hit_in;
   logic             addr_hit_ff, addr_hit_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   entry_type        hit_ent_ff, hit_ent_in;
   entry_type        pend_ff, pend_in;
   logic             pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0] sh_src_ff, sh_src_in;
   logic [IDX_W-1:0] sh_dst_ff, sh_dst_in;
   logic [CNT_W-1:0] sh_left_ff, sh_left_in;
   logic             sh_vld_ff, sh_vld_in;
   logic             sh_up_ff, sh_up_in;
   logic             stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         cmp_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
         sh_vld_ff   <= 1'b0;
         hit_ff      <= 1'b0;
         addr_hit_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         cmp_vld_ff  <= cmp_vld_in;
         pend_vld_ff <= pend_vld_in;
         sh_vld_ff   <= sh_vld_in;
         hit_ff      <= hit_in;
         addr_hit_ff <= addr_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      rd_idx_ff  <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      pos_ff     <= pos_in;
      hit_ent_ff <= hit_ent_in;
      pend_ff    <= pend_in;
      sh_src_ff  <= sh_src_in;
      sh_dst_ff  <= sh_dst_in;
      sh_left_ff <= sh_left_in;
      sh_up_ff   <= sh_up_in;
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      key_in      = key_ff;
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      cmp_idx_in  = cmp_idx_ff;
      cmp_vld_in  = cmp_vld_ff;
      hit_in      = hit_ff;
      addr_hit_in = addr_hit_ff;
      pos_in      = pos_ff;
      hit_ent_in  = hit_ent_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      sh_src_in   = sh_src_ff;
      sh_dst_in   = sh_dst_ff;
      sh_left_in  = sh_left_ff;
      sh_vld_in   = sh_vld_ff;
      sh_up_in    = sh_up_ff;
      req_ready   = 1'b0;
      mem_ctl     = '0;
      rd_addr     = rd_idx_ff[IDX_W-1:0];
      wr_addr     = sh_dst_ff;
      wr_data     = rd_data;
      out_load    = 1'b0;
      out_data    = make_rsp(STS_OK, key_ff, 1'b1);
      stall       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in = req_cmd;
               key_in = req_key;
               // unused codes are dropped here
               if (req_cmd <= 3'(CMD_LIST)) begin
                  state_in    = S_SCAN;
                  rd_idx_in   = '0;
                  cmp_vld_in  = 1'b0;
                  hit_in      = 1'b0;
                  addr_hit_in = 1'b0;
                  pend_vld_in = 1'b0;
               end
            end
         end

         S_SCAN: begin
            // a second location match needs the output register for the held one
            stall = (cmd_ff == CMD_LIST) && cmp_vld_ff && mt.loc_eq && pend_vld_ff
                    && !out_free;
            if (!stall) begin
               if (cmp_vld_ff) begin
                  if (mt.alias_eq && !hit_ff) begin
                     hit_in     = 1'b1;
                     pos_in     = cmp_idx_ff;
                     hit_ent_in = rd_data;
                  end
                  if (mt.addr_eq) begin
                     addr_hit_in = 1'b1;
                  end
                  if ((cmd_ff == CMD_LIST) && mt.loc_eq) begin
                     if (pend_vld_ff) begin
                        out_load = 1'b1;
                        out_data = make_rsp(STS_OK, pend_ff, 1'b0);
                     end
                     pend_in     = rd_data;
                     pend_vld_in = 1'b1;
                  end
               end
               if (rd_idx_ff < count_ff) begin
                  mem_ctl.rd_en = 1'b1;
                  cmp_idx_in    = rd_idx_ff[IDX_W-1:0];
                  cmp_vld_in    = 1'b1;
                  rd_idx_in     = rd_idx_ff + CNT_W'(1);
               end else begin
                  cmp_vld_in = 1'b0;
                  if (!cmp_vld_ff) begin
                     state_in = S_DECIDE;
                  end
               end
            end
         end

         S_DECIDE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
               unique case (cmd_ff)
                  CMD_ADD: begin
                     if (hit_ff) begin
                        out_data = make_rsp(STS_ALIAS_EXISTS, '0, 1'b1);
                     end else if (addr_hit_ff) begin
                        out_data = make_rsp(STS_ADDR_EXISTS, '0, 1'b1);
                     end else if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                        out_data = make_rsp(STS_FULL, '0, 1'b1);
                     end else begin
                        out_data   = make_rsp(STS_OK, key_ff, 1'b1);
                        // move every entry one place back, oldest first
                        sh_up_in   = 1'b1;
                        sh_src_in  = IDX_W'(count_ff - CNT_W'(1));
                        sh_left_in = count_ff;
                        sh_vld_in  = 1'b0;
                        state_in   = (count_ff == '0) ? S_INSERT : S_SHIFT;
                     end
                  end
                  CMD_LOOKUP: begin
                     out_data = hit_ff ? make_rsp(STS_OK, hit_ent_ff, 1'b1)
                                       : make_rsp(STS_ALIAS_MISSING, '0, 1'b1);
                  end
                  CMD_UPDATE: begin
                     if (!hit_ff) begin
                        out_data = make_rsp(STS_ALIAS_MISSING, '0, 1'b1);
                     end else if (addr_hit_ff) begin
                        out_data = make_rsp(STS_ADDR_EXISTS, '0, 1'b1);
                     end else begin
                        out_data      = make_rsp(STS_OK, key_ff, 1'b1);
                        mem_ctl.wr_en = 1'b1;
                        wr_addr       = pos_ff;
                        wr_data       = key_ff;
                     end
                  end
                  CMD_DELETE: begin
                     if (!hit_ff) begin
                        out_data = make_rsp(STS_ALIAS_MISSING, '0, 1'b1);
                     end else begin
                        out_data   = make_rsp(STS_OK, hit_ent_ff, 1'b1);
                        count_in   = count_ff - CNT_W'(1);
                        // close the gap, moving older-side entries forward
                        sh_up_in   = 1'b0;
                        sh_src_in  = pos_ff + IDX_W'(1);
                        sh_left_in = count_ff - CNT_W'(1) - CNT_W'(pos_ff);
                        sh_vld_in  = 1'b0;
                        state_in   = S_SHIFT;
                     end
                  end
                  CMD_LIST: begin
                     out_data = pend_vld_ff ? make_rsp(STS_OK, pend_ff, 1'b1)
                                            : make_rsp(STS_LOC_EMPTY, '0, 1'b1);
                  end
                  default: begin
                     out_load = 1'b0;
                  end
               endcase
            end
         end

         S_SHIFT: begin
            // read one entry, write the one read last cycle
            if (sh_vld_ff) begin
               mem_ctl.wr_en = 1'b1;
            end
            if (sh_left_ff != '0) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = sh_src_ff;
               sh_dst_in     = sh_up_ff ? sh_src_ff + IDX_W'(1) : sh_src_ff - IDX_W'(1);
               sh_src_in     = sh_up_ff ? sh_src_ff - IDX_W'(1) : sh_src_ff + IDX_W'(1);
               sh_left_in    = sh_left_ff - CNT_W'(1);
               sh_vld_in     = 1'b1;
            end else begin
               sh_vld_in = 1'b0;
               if (!sh_vld_ff) begin
                  state_in = sh_up_ff ? S_INSERT : S_IDLE;
               end
            end
         end

         S_INSERT: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = '0;
            wr_data       = key_ff;
            count_in      = count_ff + CNT_W'(1);
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign cmp_key = key_ff;
   assign count   = count_ff;

endmodule

### rtl/alias_address_table.sv
// Alias/address table: up to TABLE_DEPTH entries, each a 32-bit IPv4 address
// paired with an 80-bit alias, kept newest first in one on-chip memory. Commands
// (req_tuser) are add, lookup, update, delete and list-by-location; unused codes
// are dropped with no result. Every command scans the table once, one entry per
// cycle through a single compare unit unless a list result waits for the output
// register, then decides once it is free. Add then moves all n stored entries
// back and writes the new one at the front; delete of the entry at position p
// moves the n - 1 - p older ones forward. Worst case is an add, set by the one
// read and one write port of the entry memory. req_tready is high only while
// no command is in progress. List gives one transfer per matching entry, newest
// first, tlast on the final one, or a single location-empty transfer. A result
// waits in the output register while the next command is taken.
`include "alias_address_table_defines.svh"

module alias_address_table import aat_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,   // alias_hi[15:0], alias_lo[79:16], addr[111:80]
   input  logic [2:0]   req_tuser,   // cmd[2:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // found_addr[31:0], found_alias_hi[47:32],
                                     // found_alias_lo[111:48]
   output logic [2:0]   rsp_tuser,   // status[2:0]
   output logic         rsp_tlast
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   entry_type        req_key;
   entry_type        cmp_key;
   entry_type        rd_data;
   entry_type        wr_data;
   mem_ctl_type      mem_ctl;
   match_type        mt;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   logic             out_free;
   logic             out_load;
   rsp_type          out_data;
   logic [CNT_W-1:0] count;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   always_comb begin
      req_key.name_hi = req_tdata[15:0];
      req_key.name_lo = req_tdata[79:16];
      req_key.ip      = req_tdata[111:80];
   end

   aat_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_store (
      .clock   (clock),
      .ctl     (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // the one compare unit, fed by the memory read data during scans
   aat_match u_match (
      .ent (rd_data),
      .key (cmp_key),
      .mt  (mt)
   );

   aat_seq #(.TABLE_DEPTH(TABLE_DEPTH)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (req_tuser),
      .req_key   (req_key),
      .mem_ctl   (mem_ctl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_data   (rd_data),
      .cmp_key   (cmp_key),
      .mt        (mt),
      .out_free  (out_free),
      .out_load  (out_load),
      .out_data  (out_data),
      .count     (count)
   );

   // output register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = out_data;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.alias_lo, rsp_ff.alias_hi, rsp_ff.addr};
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_ff.last;

   // a waiting result is never overwritten
   `AAT_ASSERT_IMP(a_no_overwrite, clock, reset, out_load, out_free)
   // fill level stays within the table
   `AAT_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count <= CNT_W'(TABLE_DEPTH))
   // a real command blocks the input until it is done
   `AAT_ASSERT_NEXT(a_busy_after_cmd, clock, reset,
      req_tvalid && req_tready && (req_tuser <= 3'(CMD_LIST)), !req_tready)
   // error and empty statuses are always the final transfer
   `AAT_ASSERT_IMP(a_error_is_last, clock, reset,
      rsp_tvalid && (rsp_tuser != 3'(STS_OK)), rsp_tlast)

endmodule
